/* hw/rtl/bcis_pkg.sv */
// shared types, constants and helpers of the bus cpu instruction step block
`timescale 1ns / 1ps

package bcis_pkg;

  // data ram size and index width
  localparam int RAM_DEPTH = 256;
  localparam int IDX_W = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  // decoded-instruction queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // special pointer values
  localparam logic [7:0] ADDR_IP_HI = 8'h01;  // reads ip high, holds jump high byte
  localparam logic [7:0] ADDR_IP_LO = 8'h02;  // reads ip low, write jumps
  localparam logic [7:0] ADDR_COND_HI = 8'h03;  // high byte of the conditional jump
  localparam logic [7:0] ADDR_COND_JUMP = 8'h04;  // write jumps when a is negative
  localparam logic [7:0] ADDR_CHAR = 8'h07;  // write emits a character

  localparam logic [15:0] IP_STEP = 16'd2;

  // sink bit positions in the control word
  localparam int SNK_RAM_BIT = 0;
  localparam int SNK_PTR_BIT = 1;
  localparam int SNK_A_BIT = 2;
  localparam int SNK_B_BIT = 3;

  // source bit positions in the control word
  localparam int SRC_RAM_BIT = 4;
  localparam int SRC_PTR_BIT = 5;
  localparam int SRC_ADD_BIT = 6;
  localparam int SRC_INV_BIT = 7;

  typedef enum logic [2:0] {
    SRC_LIT,
    SRC_RAM,
    SRC_PTR,
    SRC_ADD,
    SRC_INV
  } bus_src_t;

  typedef struct packed {
    bus_src_t src;
    logic [3:0] sinks;
    logic [7:0] literal;
  } bcis_op_t;

  // pointer folded onto the ram depth, restoring compare-subtract on narrow values
  function automatic logic [IDX_W-1:0] ram_index(input logic [7:0] addr);
    int r;
    r = int'(addr);
    for (int s = 4; s >= 0; s--) begin
      if (r >= (RAM_DEPTH << s)) begin
        r = r - (RAM_DEPTH << s);
      end
    end
    return IDX_W'(r);
  endfunction

  localparam logic [IDX_W-1:0] IDX_IP_HI = ram_index(ADDR_IP_HI);
  localparam logic [IDX_W-1:0] IDX_COND_HI = ram_index(ADDR_COND_HI);

endpackage

/* hw/rtl/bcis_front.sv */
// front part: decodes the control word and queues decoded instructions
`timescale 1ns / 1ps

module bcis_front
  import bcis_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] op_ctrl,
  input  logic [7:0] literal_byte,
  output logic       q_valid,
  output bcis_op_t   q_op,
  input  logic       q_pop
);

  bcis_op_t             dec_op;
  bcis_op_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QCNT_W-1:0]    count;
  logic                 push;

  // highest set source bit wins, zero upper nibble selects the literal
  always_comb begin
    dec_op.sinks   = op_ctrl[3:0];
    dec_op.literal = literal_byte;
    if (op_ctrl[7:4] == 4'd0) begin
      dec_op.src = SRC_LIT;
    end else if (op_ctrl[SRC_INV_BIT]) begin
      dec_op.src = SRC_INV;
    end else if (op_ctrl[SRC_ADD_BIT]) begin
      dec_op.src = SRC_ADD;
    end else if (op_ctrl[SRC_PTR_BIT]) begin
      dec_op.src = SRC_PTR;
    end else begin
      dec_op.src = SRC_RAM;
    end
  end

  assign in_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_op     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= dec_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/bcis_back.sv */
// back part: machine state, data ram, execution and the result register
`timescale 1ns / 1ps

module bcis_back
  import bcis_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  bcis_op_t    q_op,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] next_ip,
  output logic        char_valid,
  output logic [7:0]  char_out
);

  logic [7:0]           acc_a;
  logic [7:0]           acc_b;
  logic [7:0]           mem_pointer;
  logic [15:0]          instr_pointer;
  logic [7:0]           ram_hi;     // copy of ram at the jump high-byte address
  logic [7:0]           ram_cond_hi;  // copy of ram at the conditional high-byte address

  logic [7:0]           data_ram [RAM_DEPTH];
  logic [RAM_DEPTH-1:0] ram_written;
  logic [7:0]           ram_at_ptr;

  logic                 fire;
  logic [7:0]           bus;
  logic                 snk_ram;
  logic                 do_jump;
  logic                 do_cond_jump;
  logic                 do_char;
  logic                 ram_we;
  logic [IDX_W-1:0]     wr_idx;
  logic [IDX_W-1:0]     rd_idx;
  logic [7:0]           mem_pointer_next;
  logic [15:0]          ip_base;
  logic [15:0]          instr_pointer_next;

  assign fire  = q_valid && (!out_valid || !out_stall);
  assign q_pop = fire;

  always_comb begin
    case (q_op.src)
      SRC_LIT: bus = q_op.literal;
      SRC_RAM: begin
        if (mem_pointer == ADDR_IP_HI) begin
          bus = instr_pointer[15:8];
        end else if (mem_pointer == ADDR_IP_LO) begin
          bus = instr_pointer[7:0];
        end else begin
          bus = ram_at_ptr;
        end
      end
      SRC_PTR: bus = mem_pointer;
      SRC_ADD: bus = acc_a + acc_b;
      SRC_INV: bus = 8'd0 - acc_a;
      default: bus = q_op.literal;
    endcase
  end

  assign snk_ram      = q_op.sinks[SNK_RAM_BIT];
  assign do_jump      = snk_ram && (mem_pointer == ADDR_IP_LO);
  assign do_cond_jump = snk_ram && (mem_pointer == ADDR_COND_JUMP);
  assign do_char      = snk_ram && (mem_pointer == ADDR_CHAR);
  assign ram_we       = fire && snk_ram && !do_jump && !do_cond_jump && !do_char;

  assign mem_pointer_next = (fire && q_op.sinks[SNK_PTR_BIT]) ? bus : mem_pointer;
  assign wr_idx = ram_index(mem_pointer);
  assign rd_idx = ram_index(mem_pointer_next);

  always_comb begin
    if (do_jump) begin
      ip_base = {ram_hi, bus};
    end else if (do_cond_jump && acc_a[7]) begin
      ip_base = {ram_cond_hi, bus};
    end else begin
      ip_base = instr_pointer;
    end
  end
  assign instr_pointer_next = ip_base + IP_STEP;

  // data ram: one write port at the old pointer, registered read at the new one
  always_ff @(posedge clk) begin
    if (ram_we) begin
      data_ram[wr_idx] <= bus;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_written <= '0;
    end else if (ram_we) begin
      ram_written[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_at_ptr <= 8'd0;
    end else if (ram_we && (wr_idx == rd_idx)) begin
      ram_at_ptr <= bus;
    end else if (ram_written[rd_idx]) begin
      ram_at_ptr <= data_ram[rd_idx];
    end else begin
      ram_at_ptr <= 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_a         <= 8'd0;
      acc_b         <= 8'd0;
      mem_pointer   <= 8'd0;
      instr_pointer <= 16'd0;
      ram_hi        <= 8'd0;
      ram_cond_hi   <= 8'd0;
    end else if (fire) begin
      mem_pointer   <= mem_pointer_next;
      instr_pointer <= instr_pointer_next;
      if (q_op.sinks[SNK_A_BIT]) begin
        acc_a <= bus;
      end
      if (q_op.sinks[SNK_B_BIT]) begin
        acc_b <= bus;
      end
      if (ram_we && (wr_idx == IDX_IP_HI)) begin
        ram_hi <= bus;
      end
      if (ram_we && (wr_idx == IDX_COND_HI)) begin
        ram_cond_hi <= bus;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      next_ip    <= instr_pointer_next;
      char_valid <= do_char;
      char_out   <= do_char ? bus : 8'd0;
    end
  end

endmodule

/* hw/rtl/bus_cpu_instruction_step_top.sv */
// top level of the bus cpu instruction step block
`timescale 1ns / 1ps

// Executes one instruction of a small 8-bit bus machine per input transfer and
// returns one result transfer per instruction, in order. Sustained rate is one
// instruction per clock: the back part retires one queued instruction every
// cycle the result register can take it, and the input is taken every cycle
// the two-entry decode queue has room. An input transfer is first written into
// the queue, then executed into the result register. The data ram is read
// with a registered port whose address is the pointer that the executing
// instruction leaves behind, so the byte at the pointer is ready for the next
// instruction; a write at the same index is forwarded. Ram reset is handled
// with one written-flag per entry, so the block is ready right after reset
// with no clearing pass.

module bus_cpu_instruction_step_top
  import bcis_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // instruction transfer
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  op_ctrl,
  input  logic [7:0]  literal_byte,
  // result transfer
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] next_ip,
  output logic        char_valid,
  output logic [7:0]  char_out
);

  // decoded instruction queue between front and back
  logic     q_valid;
  bcis_op_t q_op;
  logic     q_pop;

  // front: classify the control word and queue it
  bcis_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op_ctrl      (op_ctrl),
    .literal_byte (literal_byte),
    .q_valid      (q_valid),
    .q_op         (q_op),
    .q_pop        (q_pop)
  );

  // back: run the instruction against the machine state and present the result
  bcis_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .next_ip    (next_ip),
    .char_valid (char_valid),
    .char_out   (char_out)
  );

  // an input transfer into an empty queue is visible to the back next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !q_valid) |=> q_valid)
    else $error("accepted instruction missing from queue");

  // the back only retires when an instruction is queued and the result slot frees
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_valid && (!out_valid || !out_stall)))
    else $error("queue popped without room or data");

  // with nothing queued, a taken result leaves the result register empty
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !q_valid) |=> !out_valid)
    else $error("result repeated without a new instruction");

  // the character byte is zero unless a character is emitted
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !char_valid) |-> (char_out == 8'd0))
    else $error("character byte set without character");

endmodule
